// ----- rtl/rfa_pkg.sv -----
// Package with shared types, constants and the cosine table function of the accumulator.
`timescale 1ns / 1ps
`default_nettype none

package rfa_pkg;

    // Input beat: one coordinate of the candidate vector.
    typedef struct packed {
        logic signed [15:0] coordinate;
        logic               last;
    } t_in_beat;

    // Result beat: the negated sum of one vector.
    typedef struct packed {
        logic signed [31:0] fitness;
        logic               saturated;
    } t_out_beat;

    localparam int unsigned AMP_W       = 5;
    localparam logic [AMP_W-1:0] AMP_RESET = 5'd10;
    localparam int unsigned COS_W       = 15;
    localparam logic [15:0] ONE_Q14     = 16'd16384;
    localparam logic [30:0] SUM_MAX     = 31'h7FFF_FFFF;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Cosine of step k of a quarter wave in Q1.14, from a Taylor sum in Q30.
    // Only evaluated at elaboration to build the constant table.
    function automatic logic [15:0] quarter_cos(input int unsigned k, input int unsigned fb);
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        t    = (64'(k) * HALF_PI_Q30) >> (fb - 2);
        t2   = (t * t) >> 30;
        term = ONE_Q30;
        acc  = $signed(ONE_Q30);
        term = ((term * t2) >> 30) / 64'd2;
        acc  = acc - $signed(term);
        term = ((term * t2) >> 30) / 64'd12;
        acc  = acc + $signed(term);
        term = ((term * t2) >> 30) / 64'd30;
        acc  = acc - $signed(term);
        term = ((term * t2) >> 30) / 64'd56;
        acc  = acc + $signed(term);
        term = ((term * t2) >> 30) / 64'd90;
        acc  = acc - $signed(term);
        term = ((term * t2) >> 30) / 64'd132;
        acc  = acc + $signed(term);
        if (acc < 0) begin
            acc = 0;
        end
        return 16'(($unsigned(acc) + 64'd32768) >> 16);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rfa_fifo.sv -----
// Small synchronous FIFO built from registers, used as the term and result queues.
`timescale 1ns / 1ps
`default_nettype none

module rfa_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [WIDTH-1:0]               i_data,
    input  wire logic                           i_pop,
    output logic [WIDTH-1:0]                    o_data,
    output logic                                o_full,
    output logic                                o_empty,
    output logic [$clog2(DEPTH+1)-1:0]          o_count
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd_ptr];

    // Storage is written without reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rfa_front.sv -----
// Front section: accepts coordinates, looks up the cosine and forms each term.
`timescale 1ns / 1ps
`default_nettype none

module rfa_front #(
    parameter int unsigned FRAC_BITS = 11,
    parameter int unsigned TERM_W    = 21,
    parameter int unsigned MID_DEPTH = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  wire rfa_pkg::t_in_beat                   i_item,
    output logic                                     o_full,
    input  wire logic                                i_cfg_valid,
    input  wire logic [rfa_pkg::AMP_W-1:0]           i_cfg_data,
    input  wire logic [$clog2(MID_DEPTH+1)-1:0]      i_mid_count,
    output logic                                     o_mid_push,
    output logic [TERM_W:0]                          o_mid_data
);

    localparam int unsigned QSTEPS    = 1 << (FRAC_BITS - 2);
    localparam int unsigned IDX_W     = FRAC_BITS - 1;
    localparam int unsigned AMP_SHIFT = 14 - FRAC_BITS;
    localparam int unsigned CNT_W     = $clog2(MID_DEPTH + 1);
    localparam int unsigned SQR_W     = 32 - FRAC_BITS;

    logic [rfa_pkg::COS_W-1:0] w_tab [QSTEPS+1];

    logic [rfa_pkg::AMP_W-1:0] r_amp;
    logic                      w_accept;
    logic [FRAC_BITS-1:0]      w_phase;
    logic [1:0]                w_quad;
    logic [IDX_W-1:0]          w_idx;
    logic signed [31:0]        w_sq;
    logic [CNT_W:0]            w_used;

    logic                      r_s1_valid;
    logic                      r_s1_last;
    logic                      r_s1_neg;
    logic [30:0]               r_s1_sq;
    logic [rfa_pkg::COS_W-1:0] r_s1_cos;

    logic [15:0]               w_diff;
    logic [20:0]               w_amp_q14;
    logic [20:0]               w_amp_rnd;
    logic [31:0]               w_sq_sum;
    logic [SQR_W-1:0]          w_sq_rnd;

    logic                      r_s2_valid;
    logic                      r_s2_last;
    logic [TERM_W-1:0]         r_s2_term;

    // Constant quarter-wave cosine table, evaluated at elaboration.
    for (genvar k = 0; k <= QSTEPS; k++) begin : g_tab
        assign w_tab[k] = rfa_pkg::COS_W'(rfa_pkg::quarter_cos(k, FRAC_BITS));
    end

    // Credit check: queue entries plus beats in flight must leave a free slot.
    assign w_used   = (CNT_W+1)'(i_mid_count) + (CNT_W+1)'(r_s1_valid)
                    + (CNT_W+1)'(r_s2_valid);
    assign o_full   = (w_used >= (CNT_W+1)'(MID_DEPTH));
    assign w_accept = i_push && !o_full;

    // Amplitude register; the write channel is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= rfa_pkg::AMP_RESET;
        end else if (i_cfg_valid) begin
            r_amp <= i_cfg_data;
        end
    end

    // Phase classification: quadrant picks the mirrored index and the sign.
    assign w_phase = i_item.coordinate[FRAC_BITS-1:0];
    assign w_quad  = w_phase[FRAC_BITS-1:FRAC_BITS-2];
    assign w_idx   = w_quad[0] ? IDX_W'(QSTEPS) - IDX_W'(w_phase[FRAC_BITS-3:0])
                               : IDX_W'(w_phase[FRAC_BITS-3:0]);
    assign w_sq    = i_item.coordinate * i_item.coordinate;

    // Stage one: square and registered table read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= i_item.last;
        r_s1_neg  <= w_quad[1] ^ w_quad[0];
        r_s1_sq   <= 31'(w_sq);
        r_s1_cos  <= w_tab[w_idx];
    end

    // Amplitude part A*(1 - cos) in Q14, and the rounded square.
    assign w_diff    = r_s1_neg ? rfa_pkg::ONE_Q14 + 16'(r_s1_cos)
                                : rfa_pkg::ONE_Q14 - 16'(r_s1_cos);
    assign w_amp_q14 = 21'(r_amp) * 21'(w_diff);
    assign w_sq_sum  = 32'(r_s1_sq) + (32'd1 << (FRAC_BITS - 1));
    assign w_sq_rnd  = w_sq_sum[31:FRAC_BITS];

    if (AMP_SHIFT == 0) begin : g_no_shift
        assign w_amp_rnd = w_amp_q14;
    end else begin : g_shift
        logic [21:0] w_amp_sum;
        assign w_amp_sum = 22'(w_amp_q14) + (22'd1 << (AMP_SHIFT - 1));
        assign w_amp_rnd = 21'(w_amp_sum >> AMP_SHIFT);
    end

    // Stage two: the finished term goes to the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_last <= r_s1_last;
        r_s2_term <= TERM_W'(w_sq_rnd) + TERM_W'(w_amp_rnd);
    end

    assign o_mid_push = r_s2_valid;
    assign o_mid_data = {r_s2_term, r_s2_last};

endmodule

`default_nettype wire

// ----- rtl/rfa_back.sv -----
// Back section: saturating accumulation of terms and result generation.
`timescale 1ns / 1ps
`default_nettype none

module rfa_back #(
    parameter int unsigned TERM_W = 21
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_mid_empty,
    input  wire logic [TERM_W:0]      i_mid_data,
    output logic                      o_mid_pop,
    input  wire logic                 i_res_full,
    output logic                      o_res_push,
    output rfa_pkg::t_out_beat        o_res
);

    logic [30:0]       r_sum;
    logic              r_ovf;
    logic              w_take;
    logic              w_last;
    logic [TERM_W-1:0] w_term;
    logic [31:0]       w_sum;
    logic [30:0]       w_sum_sat;
    logic              w_ovf;

    // A term is taken only while the result queue has room.
    assign w_take    = !i_mid_empty && !i_res_full;
    assign o_mid_pop = w_take;
    assign w_last    = i_mid_data[0];
    assign w_term    = i_mid_data[TERM_W:1];

    // Saturating add of the new term.
    assign w_sum     = 32'(r_sum) + 32'(w_term);
    assign w_sum_sat = w_sum[31] ? rfa_pkg::SUM_MAX : w_sum[30:0];
    assign w_ovf     = r_ovf || w_sum[31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_ovf <= 1'b0;
        end else if (w_take) begin
            if (w_last) begin
                r_sum <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_sum <= w_sum_sat;
                r_ovf <= w_ovf;
            end
        end
    end

    // The last coordinate of a vector emits the negated sum.
    assign o_res_push      = w_take && w_last;
    assign o_res.fitness   = $signed(32'd0 - 32'(w_sum_sat));
    assign o_res.saturated = w_ovf;

endmodule

`default_nettype wire

// ----- rtl/rastrigin_fitness_accumulator_core.sv -----
// Top level of the Rastrigin fitness accumulator: front, term queue, back, result queue.
// Path: a result reaches the outputs through the two front stages, the term queue and
// the back step that writes the result queue. Throughput: one coordinate per cycle while
// full is low; a full result queue stalls the back and then, by credit, the front.
// Reset: synchronous, active low; clears the sum, the overflow flag and both queues,
// and loads the amplitude with ten.
`timescale 1ns / 1ps
`default_nettype none

module rastrigin_fitness_accumulator_core #(
    parameter int unsigned FRAC_BITS = 11
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    input  wire rfa_pkg::t_in_beat           i_item,
    output logic                             full,
    output logic                             empty,
    input  wire logic                        pop,
    output rfa_pkg::t_out_beat               o_result,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [rfa_pkg::AMP_W-1:0]   i_cfg_data
);

    localparam int unsigned SQ_PART  = 31 - FRAC_BITS;
    localparam int unsigned AMP_PART = FRAC_BITS + 7;
    localparam int unsigned TERM_W   = ((SQ_PART > AMP_PART) ? SQ_PART : AMP_PART) + 1;
    localparam int unsigned MID_DEPTH = 4;
    localparam int unsigned RES_DEPTH = 2;
    localparam int unsigned MID_CW    = $clog2(MID_DEPTH + 1);
    localparam int unsigned RES_CW    = $clog2(RES_DEPTH + 1);
    localparam int unsigned RES_W     = $bits(rfa_pkg::t_out_beat);

    logic               w_mid_push;
    logic [TERM_W:0]    w_mid_wdata;
    logic [TERM_W:0]    w_mid_rdata;
    logic               w_mid_pop;
    logic               w_mid_full;
    logic               w_mid_empty;
    logic [MID_CW-1:0]  w_mid_count;

    logic               w_res_push;
    rfa_pkg::t_out_beat w_res;
    logic               w_res_full;
    logic [RES_CW-1:0]  w_res_count;
    logic [RES_W-1:0]   w_res_rdata;

    assign o_cfg_ready = 1'b1;

    // Front: classify and form terms.
    rfa_front #(
        .FRAC_BITS (FRAC_BITS),
        .TERM_W    (TERM_W),
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_mid_count (w_mid_count),
        .o_mid_push  (w_mid_push),
        .o_mid_data  (w_mid_wdata)
    );

    // Term queue between the two sections.
    rfa_fifo #(
        .WIDTH (TERM_W + 1),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_wdata),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_rdata),
        .o_full  (w_mid_full),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    // Back: accumulate and emit.
    rfa_back #(
        .TERM_W (TERM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_mid_data  (w_mid_rdata),
        .o_mid_pop   (w_mid_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // Result queue toward the consumer.
    rfa_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_data  (w_res_rdata),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_count (w_res_count)
    );

    assign o_result = w_res_rdata;

`ifndef SYNTHESIS
    // The credit check must keep the term queue from ever being written while full.
    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_push |-> !w_mid_full)
        else $error("term queue written while full");

    // The result queue count never passes its depth.
    a_res_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_count <= RES_CW'(RES_DEPTH))
        else $error("result queue count out of range");

    // A saturated result always carries the clamped fitness.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.saturated) |-> (o_result.fitness == 32'sh8000_0001))
        else $error("saturated result with wrong fitness");

    // Fitness is never positive.
    a_fit_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.fitness[31] || (o_result.fitness == 32'sd0)))
        else $error("positive fitness on result port");
`endif

endmodule

`default_nettype wire

// ----- bench/fitness_checker.sv -----
// Checker that predicts the negated Rastrigin sum of each vector and compares every result beat.
`timescale 1ns / 1ps

module fitness_checker #(
    parameter int unsigned FRAC_BITS = 11
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic                      i_full,
    input  wire rfa_pkg::t_in_beat         i_item,
    input  wire logic                      i_empty,
    input  wire logic                      i_pop,
    input  wire rfa_pkg::t_out_beat        i_result,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      i_cfg_ready,
    input  wire logic [rfa_pkg::AMP_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int unsigned QUARTER = 1 << (FRAC_BITS - 2);

    // Quarter-wave cosine table in Q1.14 and the shadow state of the block.
    logic [15:0]               cos_quarter [0:QUARTER];
    logic [rfa_pkg::AMP_W-1:0] amp_shadow;
    logic [31:0]               sum_shadow;
    logic                      clamp_shadow;
    rfa_pkg::t_out_beat        fitness_due [$];

    // Taylor sum of cos(t) in Q30 with truncated products, rounded to Q1.14.
    function automatic logic [15:0] taylor_cos(input int unsigned k);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] mag;
        longint      acc;
        t    = (64'(k) * rfa_pkg::HALF_PI_Q30) >> (FRAC_BITS - 2);
        t2   = (t * t) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(64'd1 << 30);
        for (int unsigned n = 1; n <= 6; n++) begin
            term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        mag = acc;
        return 16'((mag + 64'd32768) >> 16);
    endfunction

    // Cosine of the fraction bits, folded from the quarter table by quadrant.
    function automatic int phase_cosine(input logic [FRAC_BITS-1:0] p);
        int unsigned quad;
        int unsigned r;
        quad = p[FRAC_BITS-1 -: 2];
        r    = p[FRAC_BITS-3:0];
        case (quad)
            0: begin
                return int'(cos_quarter[r]);
            end
            1: begin
                return -int'(cos_quarter[QUARTER - r]);
            end
            2: begin
                return -int'(cos_quarter[r]);
            end
            default: begin
                return int'(cos_quarter[QUARTER - r]);
            end
        endcase
    endfunction

    function automatic logic [63:0] round_shift(input logic [63:0] v, input int unsigned s);
        if (s == 0) begin
            return v;
        end
        return (v + (64'd1 << (s - 1))) >> s;
    endfunction

    // One coordinate's contribution: x*x plus A*(1 - cos(2*pi*x)).
    function automatic logic [63:0] rastrigin_term(input logic signed [15:0] x,
                                                   input logic [rfa_pkg::AMP_W-1:0] a);
        longint      xs;
        logic [63:0] sq;
        logic [63:0] amp_q14;
        int          c;
        xs      = x;
        sq      = xs * xs;
        c       = phase_cosine(x[FRAC_BITS-1:0]);
        amp_q14 = 64'(a) * 64'(16384 - c);
        return round_shift(sq, FRAC_BITS) + round_shift(amp_q14, 14 - FRAC_BITS);
    endfunction

    initial begin
        for (int unsigned k = 0; k <= QUARTER; k++) begin
            cos_quarter[k] = taylor_cos(k);
        end
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin : watch
        logic [63:0]        total;
        rfa_pkg::t_out_beat want;
        if (!i_rst_n) begin
            amp_shadow   = rfa_pkg::AMP_RESET;
            sum_shadow   = '0;
            clamp_shadow = 1'b0;
            fitness_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                amp_shadow = i_cfg_data;
            end
            // An accepted coordinate updates the sum; the last one closes the vector.
            if (i_push && !i_full) begin
                total = 64'(sum_shadow) + rastrigin_term(i_item.coordinate, amp_shadow);
                if (total > 64'(rfa_pkg::SUM_MAX)) begin
                    total        = 64'(rfa_pkg::SUM_MAX);
                    clamp_shadow = 1'b1;
                end
                sum_shadow = total[31:0];
                if (i_item.last) begin
                    want.fitness   = 32'd0 - sum_shadow;
                    want.saturated = clamp_shadow;
                    fitness_due.push_back(want);
                    sum_shadow   = '0;
                    clamp_shadow = 1'b0;
                end
            end
            // A result beat is matched against the oldest pending fitness.
            if (i_pop && !i_empty) begin
                if (fitness_due.size() == 0) begin
                    $error("result beat with no fitness pending: fitness %0d saturated %0b",
                           i_result.fitness, i_result.saturated);
                    o_fail_count++;
                end else begin
                    want = fitness_due.pop_front();
                    if (i_result.fitness !== want.fitness) begin
                        $error("fitness: expected %0d, actual %0d",
                               want.fitness, i_result.fitness);
                        o_fail_count++;
                    end
                    if (i_result.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, i_result.saturated);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = fitness_due.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top that drives coordinates, amplitude writes and result pops, and gives the verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned FRAC_BITS  = 11;
    localparam int          WATCHDOG   = 2000;
    localparam int          LONG_HOLD  = 400;
    localparam int          SETTLE     = 10;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      push        = 1'b0;
    rfa_pkg::t_in_beat         i_item      = '0;
    logic                      pop         = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [rfa_pkg::AMP_W-1:0] i_cfg_data  = '0;
    wire logic                 full;
    wire logic                 empty;
    wire logic                 o_cfg_ready;
    rfa_pkg::t_out_beat        o_result;

    int fail_count;
    int pending;
    bit idle_on    = 1'b1;
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;
    int quiet      = 0;

    rastrigin_fitness_accumulator_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    fitness_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_item      (i_item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Watchdog: ends the run after too many cycles without any accepted beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= WATCHDOG) begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Offer one coordinate beat and wait until it is taken.
    task automatic send_coord(input logic [15:0] x, input logic last);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push              <= 1'b1;
        i_item.coordinate <= x;
        i_item.last       <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Lower push and wait until every pending fitness has come out, then settle.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_amplitude(input logic [rfa_pkg::AMP_W-1:0] a);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= a;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly full-range coordinates, with extremes and values near zero mixed in.
    function automatic logic [15:0] pick_coord();
        logic [15:0] corners [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        case ($urandom_range(0, 9))
            0: begin
                return corners[$urandom_range(0, 3)];
            end
            1, 2: begin
                return 16'($urandom_range(0, 4095) - 2048);
            end
            default: begin
                return 16'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    // Random vectors until about n coordinates have gone in; each ends on a last beat.
    task automatic run_vectors(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                send_coord(pick_coord(), i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset amplitude: extremes, quadrant edges, negatives.
        send_coord(16'h0000, 1'b1);
        send_coord(16'h7FFF, 1'b1);
        send_coord(16'h8000, 1'b1);
        send_coord(16'hFFFF, 1'b1);
        send_coord(16'h0001, 1'b1);
        send_coord(16'h0200, 1'b1);
        send_coord(16'h0201, 1'b0);
        send_coord(16'h0400, 1'b1);
        send_coord(16'h0600, 1'b1);
        send_coord(16'h07FF, 1'b1);
        send_coord(16'h0800, 1'b1);
        send_coord(16'hF800, 1'b1);
        send_coord(16'hFE00, 1'b1);
        send_coord(16'h1234, 1'b0);
        send_coord(16'hC321, 1'b0);
        send_coord(16'h0155, 1'b1);
        send_coord(16'h8001, 1'b0);
        send_coord(16'h7FFE, 1'b1);

        write_amplitude('0);
        send_coord(16'h0400, 1'b1);
        run_vectors(160);
        write_amplitude(5'd31);
        send_coord(16'h0400, 1'b1);
        run_vectors(160);
        write_amplitude(5'($urandom_range(0, 31)));
        run_vectors(160);

        // Back-pressure: results are held off while one-beat vectors keep coming.
        write_amplitude(5'($urandom_range(0, 31)));
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 80; i++) begin
            send_coord(pick_coord(), 1'b1);
        end
        idle_on = 1'b1;

        write_amplitude(5'd1);
        run_vectors(160);
        write_amplitude(5'($urandom_range(0, 31)));
        run_vectors(160);

        // Final stretch at full rate on both sides.
        write_amplitude(5'($urandom_range(0, 31)));
        idle_on = 1'b0;
        run_vectors(160);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
